// ===== sv/wmmo_pkg.sv =====
package wmmo_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_W      = 5;
  localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_MAX) + 1;
  localparam int ALU_W      = SUM_W + 1;
  localparam int DCNT_W     = $clog2(SUM_W);

  localparam logic [CFG_W-1:0] WS_RESET = CFG_W'(15);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_ABS,
    ST_DIV,
    ST_NEG,
    ST_SCAN,
    ST_FADD,
    ST_FSUB,
    ST_FHALF,
    ST_FEST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    addr;
    logic [SAMPLE_W-1:0] data;
  } store_wr_t;

endpackage

// ===== sv/wmmo_alu.sv =====
module wmmo_alu
  import wmmo_pkg::*;
(
  input  alu_req_t         req,
  output logic [ALU_W-1:0] res
);

  assign res = req.a + (req.sub ? ~req.b : req.b) + ALU_W'(req.sub);

endmodule

// ===== sv/wmmo_store.sv =====
module wmmo_store
  import wmmo_pkg::*;
(
  input  logic                clk,
  input  store_wr_t           wr,
  input  logic [IDX_W-1:0]    raddr,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [WINDOW_MAX];
  logic [SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/window_mean_mode_offset.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    in_opcode, in_sample
// out       output     out_valid / out_stall  out_estimate
// cfg       input      cfg_we                 cfg_wdata (window_size)
//
// An add transaction raises out_valid after the sum, absolute value, division, negation,
// mode scan and estimate steps, all on the single shared adder and the sample store with
// one read port; the next transaction can be taken in the same cycle that out_valid rises.
// A clear transaction empties the window without leaving ST_IDLE. in_stall is high while a transaction is in work.
// Synchronous active-low reset; window_size returns to 15 and the window is empty.
// A stalled result is held; the next transaction may be accepted meanwhile.
module window_mean_mode_offset
  import wmmo_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_estimate
);

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    ws_r, ws_nxt;
  logic [IDX_W-1:0]    wi_r, wi_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic [SUM_W-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [SAMPLE_W-1:0] mean_r, mean_nxt;
  logic [SAMPLE_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    best_r, best_nxt;
  logic [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic [SAMPLE_W-1:0] hi_r, hi_nxt;
  logic [ALU_W-1:0]    t_r, t_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_estimate_r, out_estimate_nxt;

  alu_req_t            alu_req;
  logic [ALU_W-1:0]    alu_res;
  store_wr_t           st_wr;
  logic [IDX_W-1:0]    raddr;
  logic [SAMPLE_W-1:0] rdata;

  logic [CNT_W-1:0]    len;
  logic [IDX_W-1:0]    wi_eff;
  logic [CNT_W-1:0]    wi_inc;
  logic [CNT_W-1:0]    fill_cl;
  logic [CNT_W-1:0]    i_inc;
  logic [CNT_W-1:0]    cnt_fin;
  logic [CNT_W:0]      div_sh;
  logic                div_ok;
  logic                eq;

  wmmo_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  wmmo_store u_store (
    .clk   (clk),
    .wr    (st_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (ws_r == '0) begin
      len = CNT_W'(1);
    end else if (ws_r > WINDOW_MAX) begin
      len = CNT_W'(WINDOW_MAX);
    end else begin
      len = CNT_W'(ws_r);
    end
  end

  assign wi_eff  = (CNT_W'(wi_r) >= len) ? '0 : wi_r;
  assign wi_inc  = CNT_W'(wi_eff) + CNT_W'(1);
  assign fill_cl = (fill_r > len) ? len : fill_r;
  assign i_inc   = i_r + CNT_W'(1);
  assign eq      = (rdata == cur_r);
  assign cnt_fin = cnt_r + CNT_W'(eq);
  assign div_sh  = {rem_r, q_r[SUM_W-1]};
  assign div_ok  = ~alu_res[ALU_W-1];

  always_comb begin
    state_nxt        = state_r;
    ws_nxt           = ws_r;
    wi_nxt           = wi_r;
    fill_nxt         = fill_r;
    n_nxt            = n_r;
    k_nxt            = k_r;
    i_nxt            = i_r;
    acc_nxt          = acc_r;
    neg_nxt          = neg_r;
    q_nxt            = q_r;
    rem_nxt          = rem_r;
    dcnt_nxt         = dcnt_r;
    mean_nxt         = mean_r;
    cur_nxt          = cur_r;
    cnt_nxt          = cnt_r;
    best_nxt         = best_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    t_nxt            = t_r;
    out_valid_nxt    = out_valid_r & out_stall;
    out_estimate_nxt = out_estimate_r;
    alu_req          = '0;
    st_wr            = '0;
    raddr            = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_CLEAR) begin
            wi_nxt   = '0;
            fill_nxt = '0;
          end else begin
            st_wr.en   = 1'b1;
            st_wr.addr = wi_eff;
            st_wr.data = in_sample;
            wi_nxt     = (wi_inc >= len) ? '0 : wi_inc[IDX_W-1:0];
            fill_nxt   = (fill_cl < len) ? fill_cl + CNT_W'(1) : fill_cl;
            n_nxt      = fill_nxt;
            k_nxt      = '0;
            acc_nxt    = '0;
            state_nxt  = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        raddr       = k_r[IDX_W-1:0];
        alu_req.a   = ALU_W'($signed(acc_r));
        alu_req.b   = ALU_W'($signed(rdata));
        if (k_r != '0) begin
          acc_nxt = alu_res[SUM_W-1:0];
        end
        if (k_r == n_r) begin
          state_nxt = ST_ABS;
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end
      ST_ABS: begin
        alu_req.b   = ALU_W'($signed(acc_r));
        alu_req.sub = 1'b1;
        neg_nxt     = acc_r[SUM_W-1];
        q_nxt       = acc_r[SUM_W-1] ? alu_res[SUM_W-1:0] : acc_r;
        rem_nxt     = '0;
        dcnt_nxt    = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        alu_req.a   = ALU_W'(div_sh);
        alu_req.b   = ALU_W'(n_r);
        alu_req.sub = 1'b1;
        rem_nxt     = div_ok ? alu_res[CNT_W-1:0] : div_sh[CNT_W-1:0];
        q_nxt       = {q_r[SUM_W-2:0], div_ok};
        dcnt_nxt    = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(SUM_W - 1)) begin
          state_nxt = ST_NEG;
        end
      end
      ST_NEG: begin
        alu_req.b   = ALU_W'(q_r);
        alu_req.sub = 1'b1;
        mean_nxt    = neg_r ? alu_res[SAMPLE_W-1:0] : q_r[SAMPLE_W-1:0];
        i_nxt       = '0;
        k_nxt       = '0;
        best_nxt    = '0;
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        if (k_r < n_r) begin
          raddr = k_r[IDX_W-1:0];
        end else if (i_inc < n_r) begin
          raddr = i_inc[IDX_W-1:0];
        end
        if (k_r == '0) begin
          cur_nxt = rdata;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_fin;
        end
        if (k_r == n_r) begin
          if (cnt_fin > best_r) begin
            best_nxt = cnt_fin;
            lo_nxt   = cur_r;
            hi_nxt   = cur_r;
          end else if (cnt_fin == best_r) begin
            if ($signed(cur_r) < $signed(lo_r)) begin
              lo_nxt = cur_r;
            end
            if ($signed(cur_r) > $signed(hi_r)) begin
              hi_nxt = cur_r;
            end
          end
          k_nxt = '0;
          i_nxt = i_inc;
          if (i_inc == n_r) begin
            state_nxt = ST_FADD;
          end
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end
      ST_FADD: begin
        alu_req.a = ALU_W'($signed(lo_r));
        alu_req.b = ALU_W'($signed(hi_r));
        t_nxt     = alu_res;
        state_nxt = ST_FSUB;
      end
      ST_FSUB: begin
        alu_req.a   = t_r;
        alu_req.b   = ALU_W'($signed({mean_r, 1'b0}));
        alu_req.sub = 1'b1;
        t_nxt       = alu_res;
        state_nxt   = ST_FHALF;
      end
      ST_FHALF: begin
        // truncate toward zero on the halving
        alu_req.a = t_r;
        alu_req.b = ALU_W'(t_r[ALU_W-1]);
        t_nxt     = {alu_res[ALU_W-1], alu_res[ALU_W-1:1]};
        state_nxt = ST_FEST;
      end
      ST_FEST: begin
        alu_req.a = ALU_W'($signed(mean_r));
        alu_req.b = t_r;
        t_nxt     = alu_res;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_estimate_nxt = t_r[SAMPLE_W-1:0];
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      ws_nxt   = cfg_wdata;
      wi_nxt   = '0;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ws_r        <= WS_RESET;
      wi_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ws_r        <= ws_nxt;
      wi_r        <= wi_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r            <= n_nxt;
    k_r            <= k_nxt;
    i_r            <= i_nxt;
    acc_r          <= acc_nxt;
    neg_r          <= neg_nxt;
    q_r            <= q_nxt;
    rem_r          <= rem_nxt;
    dcnt_r         <= dcnt_nxt;
    mean_r         <= mean_nxt;
    cur_r          <= cur_nxt;
    cnt_r          <= cnt_nxt;
    best_r         <= best_nxt;
    lo_r           <= lo_nxt;
    hi_r           <= hi_nxt;
    t_r            <= t_nxt;
    out_estimate_r <= out_estimate_nxt;
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_estimate = out_estimate_r;

`ifndef NO_ASSERTIONS
  a_add_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == OP_ADD) |=> state_r == ST_SUM)
    else $error("add transaction did not start the sum pass");

  a_clear_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == OP_CLEAR) |=> state_r == ST_IDLE && fill_r == '0)
    else $error("clear transaction did not empty the window");

  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> n_r != '0 && k_r <= n_r && i_r < n_r)
    else $error("scan counters out of range");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && (!out_valid || !out_stall) |=> out_valid && state_r == ST_IDLE)
    else $error("finished estimate not presented");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW_MAX))
    else $error("fill count beyond window capacity");
`endif

endmodule
